/* src/pzv_pkg.sv */
`default_nettype none
package pzv_pkg;

	// default geometry of the fixed point formats
	localparam int SIZE_BITS_DEF = 14;
	localparam int POS_FRAC_DEF = 8;
	localparam int SCALE_FRAC_DEF = 16;

	// fixed field widths
	localparam int KIND_W = 3;
	localparam int FACTOR_W = 24;
	localparam int FACTOR_FRAC = 16;
	localparam int OUT_W = 168;

	// operation selector carried in tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_FIT = 3'd0,
		KIND_ACTUAL = 3'd1,
		KIND_RESIZE = 3'd2,
		KIND_ZOOM = 3'd3,
		KIND_PAN = 3'd4,
		KIND_MAP = 3'd5
	} kind_t;

	// sequence the controller runs for one operation
	typedef enum logic [2:0] {
		PATH_DIRECT,
		PATH_FIT,
		PATH_CLAMP,
		PATH_RESIZE,
		PATH_ZOOM,
		PATH_MAP
	} path_t;

	// datapath step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_PREP,
		OP_DIV_GO,
		OP_DIV_TAKE,
		OP_FIT_MIN,
		OP_REQ_MUL,
		OP_ZOOM_NS,
		OP_SRC_MUL,
		OP_CAND,
		OP_EXT_MUL,
		OP_CLAMP,
		OP_MAP_MUL,
		OP_MAP,
		OP_COMMIT
	} op_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIT_MIN,
		ST_REQ_MUL,
		ST_ZOOM_NS,
		ST_SRC_MUL,
		ST_CAND,
		ST_EXT_MUL,
		ST_CLAMP,
		ST_MAP_MUL,
		ST_MAP,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		op_t op;
		logic axis;
		logic load;
	} cmd_t;

	typedef struct packed {
		path_t path;
		logic div_done;
	} status_t;

	// input tdata width for a given size width, whole bytes
	function automatic int in_width(input int sb);
		return ((4 * sb + 159) >> 3) << 3;
	endfunction

endpackage
`default_nettype wire

/* src/pzv_div.sv */
`default_nettype none
module pzv_div #(
	parameter int DVW = 49,
	parameter int DSW = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [DVW-1:0] dividend,
	input wire logic [DSW-1:0] divisor,
	output logic done,
	output logic signed [DVW:0] quot
);

	localparam int CW = $clog2(DVW + 1);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [DVW-1:0] quo_q;
	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dsr_q;
	logic neg_q;

	logic [DVW-1:0] mag;
	logic [DSW:0] rem_sh;
	logic ge;
	logic [DSW-1:0] rem_nx;
	logic [DVW:0] adj;

	// magnitude of the dividend, divisor is never negative
	assign mag = dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);

	// one restoring step per cycle
	assign rem_sh = {rem_q, quo_q[DVW-1]};
	assign ge = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = ge ? DSW'(rem_sh - {1'b0, dsr_q}) : rem_sh[DSW-1:0];

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CW'(DVW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// quotient and remainder shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[DVW-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[DVW-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	// floor correction for a negative dividend
	assign adj = {1'b0, quo_q} + (DVW+1)'(rem_q != '0);
	assign quot = neg_q ? -$signed(adj) : $signed({1'b0, quo_q});
	assign done = done_q;

endmodule
`default_nettype wire

/* src/pzv_dp.sv */
`default_nettype none
module pzv_dp #(
	parameter int SIZE_BITS = pzv_pkg::SIZE_BITS_DEF,
	parameter int POS_FRAC_BITS = pzv_pkg::POS_FRAC_DEF,
	parameter int SCALE_FRAC_BITS = pzv_pkg::SCALE_FRAC_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire pzv_pkg::cmd_t cmd,
	output pzv_pkg::status_t status,
	input wire logic [pzv_pkg::in_width(SIZE_BITS)-1:0] s_tdata,
	input wire logic [pzv_pkg::KIND_W-1:0] s_tuser,
	output logic [pzv_pkg::OUT_W-1:0] m_tdata
);

	localparam int SB = SIZE_BITS;
	localparam int PF = POS_FRAC_BITS;
	localparam int SF = SCALE_FRAC_BITS;
	localparam int DVW = 33 + SF;
	localparam int QW = DVW + 1;
	localparam int PW = 66;
	localparam int VW = SB + PF;
	localparam int FW = SB + SF;
	localparam int SMW = FW + 32;
	localparam int FFB = pzv_pkg::FACTOR_FRAC;
	localparam int FAW = pzv_pkg::FACTOR_W;
	localparam logic [31:0] ONE_SCALE = 32'(1) << SF;
	localparam logic [31:0] MIN_SCALE = 32'(((5 << SF) + 50) / 100);
	localparam logic [31:0] MAX_SCALE = 32'(32) << SF;
	localparam logic [FAW-1:0] ONE_FACTOR = FAW'(1) << FFB;

	// latched input item
	pzv_pkg::kind_t kind_q;
	logic [SB-1:0] iw_q, ih_q, vw_q, vh_q;
	logic signed [31:0] px_q, py_q, dx_q, dy_q;
	logic [FAW-1:0] fac_q;

	// viewer state
	logic mode_q;
	logic [31:0] scale_q;
	logic signed [31:0] ox_q, oy_q;
	logic [SB-1:0] siw_q, sih_q, svw_q, svh_q;

	// working registers
	logic [31:0] sc_q;
	logic signed [31:0] cx_q, cy_q, rx_q, ry_q, src_q, mx_q, my_q;
	logic [FW-1:0] fx_q, fy_q;
	logic fail_q;
	logic signed [PW-1:0] prod_q;
	logic [pzv_pkg::OUT_W-1:0] out_q;

	logic use_in, allpos_in, ax;
	pzv_pkg::path_t path;
	logic [SB-1:0] sz_a, vw_a, ov_a;
	logic signed [31:0] o_a, p_a, c_a;
	logic [VW-1:0] vpos_a, spos_a, ovpos_a;

	// pick the sizes of the current axis
	assign ax = cmd.axis;
	assign use_in = (kind_q == pzv_pkg::KIND_FIT) || (kind_q == pzv_pkg::KIND_ACTUAL) ||
		(kind_q == pzv_pkg::KIND_RESIZE);
	assign allpos_in = (iw_q != '0) && (ih_q != '0) && (vw_q != '0) && (vh_q != '0);
	assign sz_a = ax ? (use_in ? ih_q : sih_q) : (use_in ? iw_q : siw_q);
	assign vw_a = ax ? (use_in ? vh_q : svh_q) : (use_in ? vw_q : svw_q);
	assign ov_a = ax ? svh_q : svw_q;
	assign o_a = ax ? oy_q : ox_q;
	assign p_a = ax ? py_q : px_q;
	assign c_a = ax ? cy_q : cx_q;
	assign vpos_a = {vw_a, {PF{1'b0}}};
	assign spos_a = {sz_a, {PF{1'b0}}};
	assign ovpos_a = {ov_a, {PF{1'b0}}};

	// sequence selection
	always_comb begin
		unique case (kind_q)
			pzv_pkg::KIND_FIT: path = allpos_in ? pzv_pkg::PATH_FIT : pzv_pkg::PATH_DIRECT;
			pzv_pkg::KIND_ACTUAL: path = pzv_pkg::PATH_CLAMP;
			pzv_pkg::KIND_RESIZE: begin
				if (mode_q) path = pzv_pkg::PATH_RESIZE;
				else path = allpos_in ? pzv_pkg::PATH_FIT : pzv_pkg::PATH_CLAMP;
			end
			pzv_pkg::KIND_ZOOM: path = pzv_pkg::PATH_ZOOM;
			pzv_pkg::KIND_PAN: path = pzv_pkg::PATH_CLAMP;
			pzv_pkg::KIND_MAP: path = pzv_pkg::PATH_MAP;
			default: path = pzv_pkg::PATH_DIRECT;
		endcase
	end

	// shared divider
	logic fit_p;
	logic signed [32:0] dd33;
	logic signed [DVW-1:0] div_dvd;
	logic [31:0] div_dsr;
	logic div_done;
	logic signed [QW-1:0] div_q;

	assign fit_p = path == pzv_pkg::PATH_FIT;
	assign dd33 = (path == pzv_pkg::PATH_RESIZE) ?
		$signed(33'(ovpos_a >> 1)) - 33'(o_a) : 33'(p_a) - 33'(o_a);
	assign div_dvd = fit_p ? DVW'({vw_a, {SF{1'b0}}}) : {dd33, {SF{1'b0}}};
	assign div_dsr = fit_p ? 32'(sz_a) : scale_q;

	pzv_div #(
		.DVW(DVW),
		.DSW(32)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.op == pzv_pkg::OP_DIV_GO),
		.dividend(div_dvd),
		.divisor(div_dsr),
		.done(div_done),
		.quot(div_q)
	);

	assign status.path = path;
	assign status.div_done = div_done;

	// quotient range and clamp to the image
	logic q_in32;
	logic signed [QW-1:0] lim_q;
	logic signed [31:0] src_cl;

	assign q_in32 = (div_q[QW-1:31] == '0) || (div_q[QW-1:31] == '1);
	assign lim_q = $signed(QW'(spos_a));
	always_comb begin
		if (div_q < 0) src_cl = '0;
		else if (div_q > lim_q) src_cl = 32'(spos_a);
		else src_cl = div_q[31:0];
	end

	// shared multiplier operands
	logic signed [32:0] mul_a;
	logic [31:0] mul_b;

	always_comb begin
		unique case (cmd.op)
			pzv_pkg::OP_REQ_MUL: begin
				mul_a = $signed({1'b0, scale_q});
				mul_b = 32'(fac_q);
			end
			pzv_pkg::OP_SRC_MUL: begin
				mul_a = 33'(src_q);
				mul_b = sc_q;
			end
			pzv_pkg::OP_EXT_MUL: begin
				mul_a = $signed(33'(sz_a));
				mul_b = sc_q;
			end
			pzv_pkg::OP_MAP_MUL: begin
				mul_a = 33'(p_a);
				mul_b = scale_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * $signed({1'b0, mul_b});
	end

	// scaled extent and per-axis clamp
	logic [PW-1:0] ext_w;
	logic ext_ovf;
	logic signed [33:0] v34, e34, lo34, c34, r34;

	assign ext_w = $unsigned(prod_q) >> (SF - PF);
	assign ext_ovf = |ext_w[PW-1:31];
	assign v34 = $signed(34'(vpos_a));
	assign e34 = $signed(34'(ext_w[30:0]));
	assign lo34 = v34 - e34;
	assign c34 = 34'(c_a);
	always_comb begin
		if (e34 < v34) r34 = lo34 >>> 1;
		else if (c34 < lo34) r34 = lo34;
		else if (c34 > 0) r34 = '0;
		else r34 = c34;
	end

	// candidate origin after resize or zoom
	logic signed [PW-1:0] sh_w, base_w, cval;
	logic cand_ok;

	assign sh_w = prod_q >>> SF;
	assign base_w = (path == pzv_pkg::PATH_ZOOM) ? PW'(p_a) : $signed(PW'(vpos_a >> 1));
	assign cval = base_w - sh_w;
	assign cand_ok = (cval[PW-1:31] == '0) || (cval[PW-1:31] == '1);

	// fit scale
	logic [FW-1:0] smin;
	logic [SMW-1:0] smin_w;

	assign smin = (fx_q < fy_q) ? fx_q : fy_q;
	assign smin_w = SMW'(smin);

	// zoom scale request
	logic [PW-1:0] req_w, ns_w;
	logic ns_bad;

	assign req_w = $unsigned(prod_q) >> FFB;
	always_comb begin
		if (req_w < PW'(MIN_SCALE)) ns_w = PW'(MIN_SCALE);
		else if (req_w > PW'(MAX_SCALE)) ns_w = PW'(MAX_SCALE);
		else ns_w = req_w;
	end
	assign ns_bad = (req_w == '0) ||
		((fac_q > ONE_FACTOR) && (ns_w <= PW'(scale_q))) ||
		((fac_q < ONE_FACTOR) && (ns_w >= PW'(scale_q)));

	// mapped point with saturation
	logic signed [PW-1:0] mval;
	logic signed [31:0] msat;

	assign mval = PW'(o_a) + sh_w;
	always_comb begin
		if ((mval[PW-1:31] == '0) || (mval[PW-1:31] == '1)) msat = mval[31:0];
		else if (mval[PW-1]) msat = 32'sh8000_0000;
		else msat = 32'sh7fff_ffff;
	end

	// preparation values
	logic signed [32:0] pcx, pcy;
	logic [VW-1:0] hvx, hvy, hix, hiy;

	assign pcx = 33'(ox_q) + 33'(dx_q);
	assign pcy = 33'(oy_q) + 33'(dy_q);
	assign hvx = {vw_q, {PF{1'b0}}} >> 1;
	assign hvy = {vh_q, {PF{1'b0}}} >> 1;
	assign hix = {iw_q, {PF{1'b0}}} >> 1;
	assign hiy = {ih_q, {PF{1'b0}}} >> 1;

	// state after the operation
	logic n_mode, n_app, n_draw;
	logic [31:0] n_scale;
	logic signed [31:0] n_ox, n_oy;
	logic [SB-1:0] n_siw, n_sih, n_svw, n_svh;

	always_comb begin
		n_mode = mode_q;
		n_scale = scale_q;
		n_ox = ox_q;
		n_oy = oy_q;
		n_siw = siw_q;
		n_sih = sih_q;
		n_svw = svw_q;
		n_svh = svh_q;
		n_app = 1'b0;
		unique case (kind_q)
			pzv_pkg::KIND_FIT: begin
				n_mode = 1'b0;
				n_scale = ONE_SCALE;
				n_ox = '0;
				n_oy = '0;
				n_siw = '0;
				n_sih = '0;
				n_svw = '0;
				n_svh = '0;
				if (!allpos_in || !fail_q) begin
					n_siw = iw_q;
					n_sih = ih_q;
					n_svw = vw_q;
					n_svh = vh_q;
					n_app = 1'b1;
					if (allpos_in) begin
						n_scale = sc_q;
						n_ox = rx_q;
						n_oy = ry_q;
					end
				end
			end
			pzv_pkg::KIND_ACTUAL: begin
				n_mode = 1'b1;
				n_scale = ONE_SCALE;
				n_ox = '0;
				n_oy = '0;
				n_siw = '0;
				n_sih = '0;
				n_svw = '0;
				n_svh = '0;
				if (!fail_q) begin
					n_ox = rx_q;
					n_oy = ry_q;
					n_siw = iw_q;
					n_sih = ih_q;
					n_svw = vw_q;
					n_svh = vh_q;
					n_app = 1'b1;
				end
			end
			pzv_pkg::KIND_RESIZE: begin
				if (!fail_q) begin
					n_ox = rx_q;
					n_oy = ry_q;
					n_siw = iw_q;
					n_sih = ih_q;
					n_svw = vw_q;
					n_svh = vh_q;
					n_app = 1'b1;
					if (fit_p) n_scale = sc_q;
				end
			end
			pzv_pkg::KIND_ZOOM: begin
				if (!fail_q) begin
					n_mode = 1'b1;
					n_scale = sc_q;
					n_ox = rx_q;
					n_oy = ry_q;
					n_app = 1'b1;
				end
			end
			pzv_pkg::KIND_PAN: begin
				if (!fail_q) begin
					n_ox = rx_q;
					n_oy = ry_q;
					n_app = 1'b1;
				end
			end
			default: begin
				n_app = 1'b0;
			end
		endcase
		n_draw = (n_siw != '0) && (n_sih != '0) && (n_svw != '0) && (n_svh != '0);
	end

	// input item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= pzv_pkg::kind_t'(s_tuser);
			iw_q <= s_tdata[SB-1:0];
			ih_q <= s_tdata[2*SB-1:SB];
			vw_q <= s_tdata[3*SB-1:2*SB];
			vh_q <= s_tdata[4*SB-1:3*SB];
			px_q <= s_tdata[4*SB+31:4*SB];
			py_q <= s_tdata[4*SB+63:4*SB+32];
			fac_q <= s_tdata[4*SB+87:4*SB+64];
			dx_q <= s_tdata[4*SB+119:4*SB+88];
			dy_q <= s_tdata[4*SB+151:4*SB+120];
		end
	end

	// working registers, one step per command
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			pzv_pkg::OP_PREP: begin
				fail_q <= 1'b0;
				mx_q <= '0;
				my_q <= '0;
				cx_q <= '0;
				cy_q <= '0;
				sc_q <= scale_q;
				unique case (kind_q)
					pzv_pkg::KIND_ACTUAL: begin
						sc_q <= ONE_SCALE;
						cx_q <= 32'(hvx) - 32'(hix);
						cy_q <= 32'(hvy) - 32'(hiy);
					end
					pzv_pkg::KIND_RESIZE: begin
						if (mode_q && scale_q == '0) fail_q <= 1'b1;
					end
					pzv_pkg::KIND_PAN: begin
						cx_q <= pcx[31:0];
						cy_q <= pcy[31:0];
						if (pcx[32] != pcx[31] || pcy[32] != pcy[31]) fail_q <= 1'b1;
					end
					pzv_pkg::KIND_ZOOM: begin
						if (fac_q == '0 || fac_q == ONE_FACTOR || scale_q == '0)
							fail_q <= 1'b1;
					end
					default: begin
						fail_q <= 1'b0;
					end
				endcase
			end
			pzv_pkg::OP_DIV_TAKE: begin
				if (fit_p) begin
					if (ax) fy_q <= div_q[FW-1:0];
					else fx_q <= div_q[FW-1:0];
				end else begin
					if (!q_in32) fail_q <= 1'b1;
					src_q <= (path == pzv_pkg::PATH_RESIZE) ? src_cl : div_q[31:0];
				end
			end
			pzv_pkg::OP_FIT_MIN: begin
				sc_q <= smin_w[31:0];
				if (smin == '0 || |smin_w[SMW-1:32]) fail_q <= 1'b1;
			end
			pzv_pkg::OP_ZOOM_NS: begin
				sc_q <= ns_w[31:0];
				if (ns_bad) fail_q <= 1'b1;
			end
			pzv_pkg::OP_CAND: begin
				if (ax) cy_q <= cval[31:0];
				else cx_q <= cval[31:0];
				if (!cand_ok) fail_q <= 1'b1;
			end
			pzv_pkg::OP_CLAMP: begin
				if (ax) ry_q <= r34[31:0];
				else rx_q <= r34[31:0];
				if (ext_ovf) fail_q <= 1'b1;
			end
			pzv_pkg::OP_MAP: begin
				if (ax) my_q <= msat;
				else mx_q <= msat;
			end
			default: begin
				fail_q <= fail_q;
			end
		endcase
	end

	// viewer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			scale_q <= ONE_SCALE;
			ox_q <= '0;
			oy_q <= '0;
			siw_q <= '0;
			sih_q <= '0;
			svw_q <= '0;
			svh_q <= '0;
		end else if (cmd.op == pzv_pkg::OP_COMMIT) begin
			mode_q <= n_mode;
			scale_q <= n_scale;
			ox_q <= n_ox;
			oy_q <= n_oy;
			siw_q <= n_siw;
			sih_q <= n_sih;
			svw_q <= n_svw;
			svh_q <= n_svh;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.op == pzv_pkg::OP_COMMIT)
			out_q <= {5'b0, my_q, mx_q, n_draw, n_oy, n_ox, n_scale, n_mode, n_app};
	end

	assign m_tdata = out_q;

endmodule
`default_nettype wire

/* src/pzv_ctrl.sv */
`default_nettype none
module pzv_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input wire logic m_tready,
	input wire pzv_pkg::status_t status,
	output pzv_pkg::cmd_t cmd
);

	pzv_pkg::state_t state_q, state_n;
	logic axis_q, axis_n;
	logic m_valid_q;
	logic out_free;

	assign out_free = !m_valid_q || m_tready;

	// next state
	always_comb begin
		state_n = state_q;
		axis_n = axis_q;
		unique case (state_q)
			pzv_pkg::ST_IDLE: begin
				axis_n = 1'b0;
				if (s_tvalid) state_n = pzv_pkg::ST_PREP;
			end
			pzv_pkg::ST_PREP: begin
				unique case (status.path)
					pzv_pkg::PATH_FIT: state_n = pzv_pkg::ST_DIV_GO;
					pzv_pkg::PATH_CLAMP: state_n = pzv_pkg::ST_EXT_MUL;
					pzv_pkg::PATH_RESIZE: state_n = pzv_pkg::ST_DIV_GO;
					pzv_pkg::PATH_ZOOM: state_n = pzv_pkg::ST_REQ_MUL;
					pzv_pkg::PATH_MAP: state_n = pzv_pkg::ST_MAP_MUL;
					default: state_n = pzv_pkg::ST_COMMIT;
				endcase
			end
			pzv_pkg::ST_DIV_GO: state_n = pzv_pkg::ST_DIV_WAIT;
			pzv_pkg::ST_DIV_WAIT: begin
				if (status.div_done) begin
					if (status.path == pzv_pkg::PATH_FIT) begin
						if (axis_q) begin
							state_n = pzv_pkg::ST_FIT_MIN;
							axis_n = 1'b0;
						end else begin
							state_n = pzv_pkg::ST_DIV_GO;
							axis_n = 1'b1;
						end
					end else begin
						state_n = pzv_pkg::ST_SRC_MUL;
					end
				end
			end
			pzv_pkg::ST_FIT_MIN: state_n = pzv_pkg::ST_EXT_MUL;
			pzv_pkg::ST_REQ_MUL: state_n = pzv_pkg::ST_ZOOM_NS;
			pzv_pkg::ST_ZOOM_NS: state_n = pzv_pkg::ST_DIV_GO;
			pzv_pkg::ST_SRC_MUL: state_n = pzv_pkg::ST_CAND;
			pzv_pkg::ST_CAND: begin
				if (axis_q) begin
					state_n = pzv_pkg::ST_EXT_MUL;
					axis_n = 1'b0;
				end else begin
					state_n = pzv_pkg::ST_DIV_GO;
					axis_n = 1'b1;
				end
			end
			pzv_pkg::ST_EXT_MUL: state_n = pzv_pkg::ST_CLAMP;
			pzv_pkg::ST_CLAMP: begin
				if (axis_q) begin
					state_n = pzv_pkg::ST_COMMIT;
				end else begin
					state_n = pzv_pkg::ST_EXT_MUL;
					axis_n = 1'b1;
				end
			end
			pzv_pkg::ST_MAP_MUL: state_n = pzv_pkg::ST_MAP;
			pzv_pkg::ST_MAP: begin
				if (axis_q) begin
					state_n = pzv_pkg::ST_COMMIT;
				end else begin
					state_n = pzv_pkg::ST_MAP_MUL;
					axis_n = 1'b1;
				end
			end
			pzv_pkg::ST_COMMIT: begin
				if (out_free) state_n = pzv_pkg::ST_IDLE;
			end
			default: state_n = pzv_pkg::ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd.axis = axis_q;
		cmd.load = (state_q == pzv_pkg::ST_IDLE) && s_tvalid;
		unique case (state_q)
			pzv_pkg::ST_PREP: cmd.op = pzv_pkg::OP_PREP;
			pzv_pkg::ST_DIV_GO: cmd.op = pzv_pkg::OP_DIV_GO;
			pzv_pkg::ST_DIV_WAIT:
				cmd.op = status.div_done ? pzv_pkg::OP_DIV_TAKE : pzv_pkg::OP_NONE;
			pzv_pkg::ST_FIT_MIN: cmd.op = pzv_pkg::OP_FIT_MIN;
			pzv_pkg::ST_REQ_MUL: cmd.op = pzv_pkg::OP_REQ_MUL;
			pzv_pkg::ST_ZOOM_NS: cmd.op = pzv_pkg::OP_ZOOM_NS;
			pzv_pkg::ST_SRC_MUL: cmd.op = pzv_pkg::OP_SRC_MUL;
			pzv_pkg::ST_CAND: cmd.op = pzv_pkg::OP_CAND;
			pzv_pkg::ST_EXT_MUL: cmd.op = pzv_pkg::OP_EXT_MUL;
			pzv_pkg::ST_CLAMP: cmd.op = pzv_pkg::OP_CLAMP;
			pzv_pkg::ST_MAP_MUL: cmd.op = pzv_pkg::OP_MAP_MUL;
			pzv_pkg::ST_MAP: cmd.op = pzv_pkg::OP_MAP;
			pzv_pkg::ST_COMMIT: cmd.op = out_free ? pzv_pkg::OP_COMMIT : pzv_pkg::OP_NONE;
			default: cmd.op = pzv_pkg::OP_NONE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pzv_pkg::ST_IDLE;
			axis_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			axis_q <= axis_n;
			if (state_q == pzv_pkg::ST_COMMIT && out_free) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	assign s_tready = state_q == pzv_pkg::ST_IDLE;
	assign m_tvalid = m_valid_q;

endmodule
`default_nettype wire

/* src/pan_zoom_viewport_controller.sv */
// Pan and zoom viewport controller: keeps the image-to-display mapping.
// Slave stream: one transfer per operation, the operation kind in s_tuser,
// sizes, point, zoom factor and pan offset packed in s_tdata.
// Master stream: one transfer per operation with the applied flag, the
// new mode, scale and origin, the drawable flag and the mapped point.
// Operations run one at a time on a shared iterative divider (one quotient
// bit a cycle) and one shared multiplier.
// The next item is taken once the current result sits in the output
// register; a result still waiting holds the following one back only at
// its final commit step.
// After reset the view is fit mode, scale 1.0, origin zero, sizes zero.
// A stalled receiver keeps m_tdata stable until the transfer completes.
`default_nettype none
module pan_zoom_viewport_controller #(
	parameter int SIZE_BITS = pzv_pkg::SIZE_BITS_DEF,
	parameter int POS_FRAC_BITS = pzv_pkg::POS_FRAC_DEF,
	parameter int SCALE_FRAC_BITS = pzv_pkg::SCALE_FRAC_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// image_width, image_height, view_width, view_height, pos_x, pos_y,
	// zoom_factor, pan_dx, pan_dy, zero fill
	input wire logic [pzv_pkg::in_width(SIZE_BITS)-1:0] s_tdata,
	// kind
	input wire logic [pzv_pkg::KIND_W-1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// applied, mode_now, scale_now, origin_x_now, origin_y_now, drawable_now,
	// mapped_x, mapped_y, zero fill
	output logic [pzv_pkg::OUT_W-1:0] m_tdata
);

	pzv_pkg::cmd_t cmd;
	pzv_pkg::status_t status;

	// sequencer
	pzv_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status(status),
		.cmd(cmd)
	);

	// arithmetic and state
	pzv_dp #(
		.SIZE_BITS(SIZE_BITS),
		.POS_FRAC_BITS(POS_FRAC_BITS),
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tdata(m_tdata)
	);

endmodule
`default_nettype wire
